// ----- rtl/cfwo_pkg.sv -----
// Shared types, constants and helpers for the sensor-record ring FIFO.
// Depends on nothing; every other file of the block but cfwo_ram imports it.
`timescale 1ns / 1ps

package cfwo_pkg;

  // Ring geometry.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Field widths of one record and of the reported fill count.
  localparam int unsigned FLOAT_W = 32;
  localparam int unsigned IDENT_W = 8;
  localparam int unsigned STAT_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned FILL_W  = 5;
  localparam int unsigned MEAS_W  = 2 * FLOAT_W;
  localparam int unsigned TAG_W   = IDENT_W + STAT_W + TIME_W;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ACT_ENQ      = 2'd0,
    ACT_ENQ_OVER = 2'd1,
    ACT_DEQ      = 2'd2,
    ACT_PEEK     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CODE_OK    = 2'd0,
    CODE_FULL  = 2'd1,
    CODE_EMPTY = 2'd2
  } code_e;

  // Memory operation and outcome decided for one accepted word.
  typedef struct packed {
    logic  wr_en;
    ptr_t  wr_addr;
    logic  rd_en;
    ptr_t  rd_addr;
    code_e code;
    cnt_t  count_after;
  } mem_op_t;

  // Advance a ring pointer with wrap at the last slot.
  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

endpackage

// ----- rtl/cfwo_if.sv -----
// Valid/ready channel interfaces for the request and result words.
// Depends on cfwo_pkg for field widths.
`timescale 1ns / 1ps

// Request channel: one operation with the record to store.
interface cfwo_in_if;
  import cfwo_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [FLOAT_W-1:0]   temperature_bits;
  logic [FLOAT_W-1:0]   humidity_bits;
  logic [IDENT_W-1:0]   sensor_ident;
  logic [STAT_W-1:0]    reading_status;
  logic [TIME_W-1:0]    reading_time;

  modport source (output valid, action, temperature_bits, humidity_bits,
                  sensor_ident, reading_status, reading_time, input ready);
  modport sink   (input valid, action, temperature_bits, humidity_bits,
                  sensor_ident, reading_status, reading_time, output ready);
endinterface

// Result channel: outcome code, record read and fill status.
interface cfwo_out_if;
  import cfwo_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           result_code;
  logic [FLOAT_W-1:0]   out_temperature_bits;
  logic [FLOAT_W-1:0]   out_humidity_bits;
  logic [IDENT_W-1:0]   out_sensor_ident;
  logic [STAT_W-1:0]    out_reading_status;
  logic [TIME_W-1:0]    out_reading_time;
  logic [FILL_W-1:0]    fill_count;
  logic                 is_empty;
  logic                 is_full;

  modport source (output valid, result_code, out_temperature_bits, out_humidity_bits,
                  out_sensor_ident, out_reading_status, out_reading_time,
                  fill_count, is_empty, is_full, input ready);
  modport sink   (input valid, result_code, out_temperature_bits, out_humidity_bits,
                  out_sensor_ident, out_reading_status, out_reading_time,
                  fill_count, is_empty, is_full, output ready);
endinterface

// ----- rtl/circular_fifo_with_overwrite.sv -----
// Sensor-record ring FIFO with enqueue, overwriting enqueue, dequeue and peek.
// A request word is accepted each cycle that the result side keeps moving; its
// result word passes the registered read of the record memories and then the
// output register. Sustained rate is one word per cycle while the result side
// keeps taking words. Enqueue is refused when 16 records are held, dequeue and
// peek when none are; every result reports the fill count and empty and full
// flags, and the record fields are zero unless a record was read.
// Depends on cfwo_pkg, cfwo_if, cfwo_ram and cfwo_ctrl.
`timescale 1ns / 1ps

module circular_fifo_with_overwrite
  import cfwo_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cfwo_in_if.sink    in_ch,
  cfwo_out_if.source out_ch
);

  mem_op_t          op;
  logic             fire;
  logic             s1_move;
  logic [MEAS_W-1:0] meas_wdata, meas_rdata;
  logic [TAG_W-1:0]  tag_wdata, tag_rdata;

  // Stage 1 waits for memory read data.
  logic   s1_valid_q;
  logic   s1_read_q;
  code_e  s1_code_q;
  cnt_t   s1_count_q;

  // Output register.
  logic              out_valid_q;
  code_e             out_code_q;
  logic [MEAS_W-1:0] out_meas_q;
  logic [TAG_W-1:0]  out_tag_q;
  cnt_t              out_count_q;

  // Handshake: stage 1 drains whenever the output register is free or taken.
  assign s1_move     = !out_valid_q || out_ch.ready;
  assign in_ch.ready = !s1_valid_q || s1_move;
  assign fire        = in_ch.valid && in_ch.ready;

  cfwo_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .action_i (in_ch.action),
    .op_o     (op)
  );

  // Record packing: temperature over humidity, then id, status and time.
  assign meas_wdata = {in_ch.temperature_bits, in_ch.humidity_bits};
  assign tag_wdata  = {in_ch.sensor_ident, in_ch.reading_status, in_ch.reading_time};

  cfwo_ram #(.Width(MEAS_W), .Depth(DEPTH)) u_meas_ram (
    .clk_i   (clk_i),
    .we_i    (op.wr_en),
    .waddr_i (op.wr_addr),
    .wdata_i (meas_wdata),
    .re_i    (op.rd_en),
    .raddr_i (op.rd_addr),
    .rdata_o (meas_rdata)
  );

  cfwo_ram #(.Width(TAG_W), .Depth(DEPTH)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (op.wr_en),
    .waddr_i (op.wr_addr),
    .wdata_i (tag_wdata),
    .re_i    (op.rd_en),
    .raddr_i (op.rd_addr),
    .rdata_o (tag_rdata)
  );

  // Stage 1 and output valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_q <= fire;
      end
      if (s1_valid_q && s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage 1 and output payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_read_q  <= op.rd_en;
      s1_code_q  <= op.code;
      s1_count_q <= op.count_after;
    end
    if (s1_valid_q && s1_move) begin
      out_code_q  <= s1_code_q;
      out_count_q <= s1_count_q;
      out_meas_q  <= s1_read_q ? meas_rdata : '0;
      out_tag_q   <= s1_read_q ? tag_rdata : '0;
    end
  end

  // Result word.
  assign out_ch.valid                = out_valid_q;
  assign out_ch.result_code          = out_code_q;
  assign out_ch.out_temperature_bits = out_meas_q[MEAS_W-1:FLOAT_W];
  assign out_ch.out_humidity_bits    = out_meas_q[FLOAT_W-1:0];
  assign out_ch.out_sensor_ident     = out_tag_q[TAG_W-1:STAT_W+TIME_W];
  assign out_ch.out_reading_status   = out_tag_q[STAT_W+TIME_W-1:TIME_W];
  assign out_ch.out_reading_time     = out_tag_q[TIME_W-1:0];
  assign out_ch.fill_count           = FILL_W'(out_count_q);
  assign out_ch.is_empty             = (out_count_q == '0);
  assign out_ch.is_full              = (out_count_q == CNT_W'(DEPTH));

endmodule

// ----- rtl/cfwo_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module cfwo_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/cfwo_ctrl.sv -----
// Pointer and count control: decides the memory access and outcome of each word.
// Depends on cfwo_pkg.
`timescale 1ns / 1ps

module cfwo_ctrl
  import cfwo_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  logic [1:0] action_i,
  output mem_op_t op_o
);

  ptr_t wp_q, wp_d;
  ptr_t rp_q, rp_d;
  cnt_t cnt_q, cnt_d;
  logic full;
  logic empty;
  action_e act;

  assign full  = (cnt_q == CNT_W'(DEPTH));
  assign empty = (cnt_q == '0);
  assign act   = action_e'(action_i);

  // Decode the operation against the current fill state.
  always_comb begin
    wp_d          = wp_q;
    rp_d          = rp_q;
    cnt_d         = cnt_q;
    op_o.wr_en    = 1'b0;
    op_o.wr_addr  = wp_q;
    op_o.rd_en    = 1'b0;
    op_o.rd_addr  = rp_q;
    op_o.code     = CODE_OK;
    if (fire_i) begin
      case (act)
        ACT_ENQ: begin
          if (full) begin
            op_o.code = CODE_FULL;
          end else begin
            op_o.wr_en = 1'b1;
            wp_d       = ptr_next(wp_q);
            cnt_d      = cnt_q + CNT_W'(1);
          end
        end
        ACT_ENQ_OVER: begin
          // When full, the oldest record is dropped by moving past it.
          op_o.wr_en = 1'b1;
          wp_d       = ptr_next(wp_q);
          if (full) begin
            rp_d = ptr_next(rp_q);
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        ACT_DEQ, ACT_PEEK: begin
          if (empty) begin
            op_o.code = CODE_EMPTY;
          end else begin
            op_o.rd_en = 1'b1;
            if (act == ACT_DEQ) begin
              rp_d  = ptr_next(rp_q);
              cnt_d = cnt_q - CNT_W'(1);
            end
          end
        end
        default: begin
          op_o.code = CODE_OK;
        end
      endcase
    end
    op_o.count_after = cnt_d;
  end

  // Pointer and count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // The count never goes beyond the ring size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // Empty and full rings both have the pointers on the same slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty || full) |-> (wp_q == rp_q))
    else $error("pointers disagree with fill count");

  // A plain enqueue into a full ring must not touch the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && act == ACT_ENQ && full) |-> (!op_o.wr_en && op_o.code == CODE_FULL))
    else $error("enqueue into full ring was not refused");

  // One word reads or writes the memory, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(op_o.wr_en && op_o.rd_en))
    else $error("read and write issued together");

endmodule

// ----- tb/circular_fifo_with_overwrite_tb.sv -----
// Self-checking testbench for the sensor-record ring FIFO with overwrite.
// Depends on cfwo_pkg, cfwo_if and circular_fifo_with_overwrite; a scoreboard
// class predicts every result word and compares it as it leaves the block.
`timescale 1ns / 1ps

module circular_fifo_with_overwrite_tb;
  import cfwo_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_CAP   = 200;

  // One request word as the sender offers it.
  typedef struct packed {
    action_e             action;
    logic [FLOAT_W-1:0]  temperature;
    logic [FLOAT_W-1:0]  humidity;
    logic [IDENT_W-1:0]  ident;
    logic [STAT_W-1:0]   status;
    logic [TIME_W-1:0]   stamp;
  } request_t;

  // One result word, expected or observed.
  typedef struct packed {
    code_e               code;
    logic [FLOAT_W-1:0]  temperature;
    logic [FLOAT_W-1:0]  humidity;
    logic [IDENT_W-1:0]  ident;
    logic [STAT_W-1:0]   status;
    logic [TIME_W-1:0]   stamp;
    logic [FILL_W-1:0]   fill;
    logic                empty;
    logic                full;
  } outcome_t;

  // Mirror of the ring plus the queue of outcomes still to come out.
  class record_fifo_board;
    logic [MEAS_W-1:0] meas_mem [DEPTH];
    logic [TAG_W-1:0]  tag_mem [DEPTH];
    int unsigned       wr_slot;
    int unsigned       rd_slot;
    int unsigned       held;
    outcome_t          expected_q[$];
    int unsigned       errors;

    function new();
      wr_slot = 0;
      rd_slot = 0;
      held    = 0;
      errors  = 0;
    endfunction

    function int unsigned wrap_inc(input int unsigned p);
      return (p + 1 >= DEPTH) ? 0 : p + 1;
    endfunction

    function void store_record(input request_t r);
      meas_mem[wr_slot] = {r.temperature, r.humidity};
      tag_mem[wr_slot]  = {r.ident, r.status, r.stamp};
      wr_slot = wrap_inc(wr_slot);
    endfunction

    // Apply one accepted request to the mirror and queue its outcome.
    function void note_request(input request_t r);
      outcome_t e;
      logic     was_full;
      logic     was_empty;
      e = '0;
      e.code = CODE_OK;
      was_full  = (held >= DEPTH);
      was_empty = (held == 0);
      case (r.action)
        ACT_ENQ: begin
          if (was_full) begin
            e.code = CODE_FULL;
          end else begin
            store_record(r);
            held++;
          end
        end
        ACT_ENQ_OVER: begin
          // A full ring drops its oldest record to make room.
          if (was_full) begin
            rd_slot = wrap_inc(rd_slot);
          end else begin
            held++;
          end
          store_record(r);
        end
        default: begin
          if (was_empty) begin
            e.code = CODE_EMPTY;
          end else begin
            {e.temperature, e.humidity}   = meas_mem[rd_slot];
            {e.ident, e.status, e.stamp}  = tag_mem[rd_slot];
            if (r.action == ACT_DEQ) begin
              rd_slot = wrap_inc(rd_slot);
              held--;
            end
          end
        end
      endcase
      e.fill  = FILL_W'(held);
      e.empty = (held == 0);
      e.full  = (held >= DEPTH);
      expected_q.push_back(e);
    endfunction

    task report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      if (errors <= PRINT_CAP) begin
        $display("%0t mismatch: %s got %0h expected %0h", $time, what, got, want);
      end
    endtask

    // Compare one observed result word against the oldest expectation.
    task check_result(input outcome_t got);
      outcome_t want;
      if (expected_q.size() == 0) begin
        report("result word with nothing expected", 64'(got.code), 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (got.code !== want.code)
          report("result_code", 64'(got.code), 64'(want.code));
        if (got.temperature !== want.temperature)
          report("out_temperature_bits", 64'(got.temperature), 64'(want.temperature));
        if (got.humidity !== want.humidity)
          report("out_humidity_bits", 64'(got.humidity), 64'(want.humidity));
        if (got.ident !== want.ident)
          report("out_sensor_ident", 64'(got.ident), 64'(want.ident));
        if (got.status !== want.status)
          report("out_reading_status", 64'(got.status), 64'(want.status));
        if (got.stamp !== want.stamp)
          report("out_reading_time", 64'(got.stamp), 64'(want.stamp));
        if (got.fill !== want.fill)
          report("fill_count", 64'(got.fill), 64'(want.fill));
        if (got.empty !== want.empty)
          report("is_empty", 64'(got.empty), 64'(want.empty));
        if (got.full !== want.full)
          report("is_full", 64'(got.full), 64'(want.full));
      end
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cfwo_in_if  req_ch ();
  cfwo_out_if res_ch ();

  circular_fifo_with_overwrite DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  record_fifo_board board;
  int unsigned      tx_idle_pct  = 0;
  int unsigned      rx_stall_pct = 0;
  logic             rx_hold      = 1'b0;
  int unsigned      cycle_count  = 0;

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Give up if the run hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("circular_fifo_with_overwrite_tb NOT OK");
      $finish;
    end
  end

  // Result side: ready changes at the falling edge, held low during a hold-off.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Check every result word taken at a rising edge.
  always @(posedge clk_i) begin
    outcome_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.code        = code_e'(res_ch.result_code);
      got.temperature = res_ch.out_temperature_bits;
      got.humidity    = res_ch.out_humidity_bits;
      got.ident       = res_ch.out_sensor_ident;
      got.status      = res_ch.out_reading_status;
      got.stamp       = res_ch.out_reading_time;
      got.fill        = res_ch.fill_count;
      got.empty       = res_ch.is_empty;
      got.full        = res_ch.is_full;
      board.check_result(got);
    end
  end

  // Offer one request word from a falling edge until it is taken.
  task automatic push_request(input request_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid            <= 1'b1;
    req_ch.action           <= r.action;
    req_ch.temperature_bits <= r.temperature;
    req_ch.humidity_bits    <= r.humidity;
    req_ch.sensor_ident     <= r.ident;
    req_ch.reading_status   <= r.status;
    req_ch.reading_time     <= r.stamp;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    board.note_request(r);
    @(negedge clk_i);
  endtask

  // Mostly random words, with the all-zeros and all-ones patterns now and then.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic request_t make_request(input action_e a);
    request_t r;
    r.action      = a;
    r.temperature = pick_word();
    r.humidity    = pick_word();
    r.ident       = 8'(pick_word());
    r.status      = 8'(pick_word());
    r.stamp       = pick_word();
    return r;
  endfunction

  // Random traffic that swings between filling, draining and a balanced mix,
  // so the ring spends time empty, full and everywhere in between.
  task automatic random_traffic(input int unsigned n);
    int unsigned mode;
    int unsigned left_in_mode;
    int unsigned roll;
    action_e     a;
    mode = 0;
    left_in_mode = 0;
    repeat (n) begin
      if (left_in_mode == 0) begin
        mode = $urandom_range(2);
        left_in_mode = $urandom_range(60, 15);
      end
      left_in_mode--;
      roll = $urandom_range(99);
      case (mode)
        0:       a = (roll < 40) ? ACT_ENQ : (roll < 70) ? ACT_ENQ_OVER :
                     (roll < 85) ? ACT_DEQ : ACT_PEEK;
        1:       a = (roll < 10) ? ACT_ENQ : (roll < 20) ? ACT_ENQ_OVER :
                     (roll < 80) ? ACT_DEQ : ACT_PEEK;
        default: a = action_e'(roll % 4);
      endcase
      push_request(make_request(a));
    end
  endtask

  initial begin
    request_t r;
    board = new();
    req_ch.valid            = 1'b0;
    req_ch.action           = ACT_ENQ;
    req_ch.temperature_bits = '0;
    req_ch.humidity_bits    = '0;
    req_ch.sensor_ident     = '0;
    req_ch.reading_status   = '0;
    req_ch.reading_time     = '0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: refused reads on an empty ring.
    push_request(make_request(ACT_PEEK));
    push_request(make_request(ACT_DEQ));

    // Directed: records at the field extremes; the all-ones one is read back.
    r = '{ACT_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF};
    push_request(r);
    r = '{ACT_ENQ, 32'h0, 32'h0, 8'h0, 8'h0, 32'h0};
    push_request(r);
    push_request(make_request(ACT_PEEK));
    push_request(make_request(ACT_DEQ));

    // Directed: fill to the top with overwriting enqueues, then hit the full cases.
    repeat (15) push_request(make_request(ACT_ENQ_OVER));
    push_request(make_request(ACT_ENQ));
    push_request(make_request(ACT_ENQ_OVER));
    push_request(make_request(ACT_PEEK));
    push_request(make_request(ACT_DEQ));

    // Back-pressure: results are held off while requests keep coming.
    fork
      begin
        @(posedge clk_i);
        rx_hold = 1'b1;
        repeat (80) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    random_traffic(40);

    // Random traffic under each idling pattern.
    tx_idle_pct = 0;  rx_stall_pct = 0;  random_traffic(375);
    tx_idle_pct = 86; rx_stall_pct = 0;  random_traffic(375);
    tx_idle_pct = 0;  rx_stall_pct = 86; random_traffic(375);
    tx_idle_pct = 33; rx_stall_pct = 33; random_traffic(375);

    req_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("circular_fifo_with_overwrite_tb OK");
    end else begin
      $display("circular_fifo_with_overwrite_tb NOT OK");
    end
    $finish;
  end

endmodule
